FILE: hw/rtl/mpdb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mpdb_pkg;

	localparam int STRIPS_DEF = 8;
	localparam int ROWS_DEF   = 6;

	localparam int STRIP_W = 3;
	localparam int LEVEL_W = 4;
	localparam int TIME_W  = 32;
	localparam int DECAY_W = 16;
	localparam int PEAK_W  = 11;
	localparam int BAR_W   = 6;
	localparam int ROWS_W  = 4;

	localparam int Q8_SHIFT    = 8;
	localparam int LEVEL_SHIFT = 7;
	localparam int BAR_MIN_Q8  = 13;
	localparam int Q8_HALF     = 128;

	localparam logic [DECAY_W-1:0] DECAY_RST = 16'd1000;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// register index, taken from paddr[2]
	localparam logic REG_DECAY = 1'b0;

	localparam logic KIND_LEVEL = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_WALK,
		ST_EMIT
	} mpdb_state_t;

	typedef struct packed {
		logic level_wr;
		logic capture;
		logic div_start;
		logic drop_clear;
		logic drop_load;
		logic walk;
		logic stamp_upd;
		logic emit_load;
	} mpdb_cmd_t;

	typedef struct packed {
		logic use_div;
		logic div_done;
		logic emit_hit;
		logic out_free;
	} mpdb_stat_t;

	// top-down led bar from a q8 level
	function automatic logic [BAR_W-1:0] bar_of(input logic [PEAK_W-1:0] q8,
			input logic [ROWS_W-1:0] rows);
		logic [PEAK_W:0] sum;
		logic [ROWS_W-1:0] n;
		logic [7:0] lit;
		sum = {1'b0, q8} + (PEAK_W+1)'(Q8_HALF);
		n = ROWS_W'(sum >> Q8_SHIFT);
		if (n == '0)
			n = ROWS_W'(1);
		if (n > rows)
			n = rows;
		for (int j = 0; j < 8; j++)
			lit[j] = (ROWS_W'(j) < rows) && ((ROWS_W'(j) + n) >= rows);
		if (q8 < PEAK_W'(BAR_MIN_Q8))
			lit = '0;
		return lit[BAR_W-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/mpdb_div.sv
`timescale 1ns / 1ps
`default_nettype none
module mpdb_div import mpdb_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [TIME_W-1:0]  dividend,
	input  wire logic [DECAY_W-1:0] divisor,
	output logic                    done,
	output logic [TIME_W-1:0]       quotient
);

	localparam int CNT_W = $clog2(TIME_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_W - 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [TIME_W-1:0]  quo_q;
	logic [DECAY_W-1:0] rem_q;
	logic [DECAY_W-1:0] dsr_q;

	logic [DECAY_W:0] trial;
	logic [DECAY_W:0] diff;
	logic             ge;

	// restoring division, one quotient bit per cycle
	always_comb begin
		trial = {rem_q, quo_q[TIME_W-1]};
		diff  = trial - {1'b0, dsr_q};
		ge    = trial >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DECAY_W-1:0] : trial[DECAY_W-1:0];
			quo_q <= {quo_q[TIME_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && (cnt_q == '0))
		else $error("divider did not start");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while busy");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (cnt_q == CNT_LAST) |=> done_q && !busy_q)
		else $error("divider missed its last step");

endmodule
`default_nettype wire

FILE: hw/rtl/mpdb_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module mpdb_dp import mpdb_pkg::*; #(
	parameter int STRIPS = STRIPS_DEF,
	parameter int ROWS   = ROWS_DEF,
	localparam int IW    = (STRIPS > 1) ? $clog2(STRIPS) : 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mpdb_cmd_t          cmd,
	input  wire logic [IW-1:0]      idx,
	output mpdb_stat_t              stat,
	input  wire logic [STRIP_W-1:0] strip,
	input  wire logic [LEVEL_W-1:0] level,
	input  wire logic [TIME_W-1:0]  now_ms,
	input  wire logic [DECAY_W-1:0] decay_ms,
	input  wire logic               out_ready,
	output logic                    out_valid,
	output logic [STRIP_W-1:0]      out_strip,
	output logic [BAR_W-1:0]        bar_bits,
	output logic                    last
);

	localparam int FULL_W = PEAK_W + 1;
	localparam logic [FULL_W-1:0] FULL_Q8 = FULL_W'(ROWS) << Q8_SHIFT;
	localparam logic [TIME_W-1:0] FULL_T  = TIME_W'(ROWS) << Q8_SHIFT;

	logic [PEAK_W-1:0]  peak_q [STRIPS];
	logic [BAR_W-1:0]   shown_q [STRIPS];
	logic [STRIPS-1:0]  sent_q;
	logic [STRIPS-1:0]  emit_q;
	logic [TIME_W-1:0]  stamp_q;
	logic               stamp_valid_q;
	logic [TIME_W-1:0]  now_q;
	logic [TIME_W-1:0]  drop_q;
	logic               out_valid_q;
	logic [STRIP_W-1:0] out_strip_q;
	logic [BAR_W-1:0]   bar_q;
	logic               last_q;

	logic [IW-1:0]      pidx;
	logic [PEAK_W-1:0]  cur_rd;
	logic               strip_ok;
	logic [FULL_W-1:0]  q8_in;
	logic [FULL_W-1:0]  q8_cap;
	logic [PEAK_W-1:0]  held;
	logic [PEAK_W-1:0]  lvl_new;
	logic [TIME_W-1:0]  num;
	logic               sat;
	logic [PEAK_W-1:0]  dec;
	logic [BAR_W-1:0]   bits;
	logic               hit;
	logic               is_last;
	logic               div_done;
	logic [TIME_W-1:0]  quotient;

	// one read port into the peak store
	assign pidx   = cmd.walk ? idx : strip[IW-1:0];
	assign cur_rd = peak_q[pidx];

	always_comb begin
		strip_ok = {1'b0, strip} < (STRIP_W+1)'(STRIPS);
		q8_in    = FULL_W'(level) << LEVEL_SHIFT;
		q8_cap   = (q8_in > FULL_Q8) ? FULL_Q8 : q8_in;
		// with decay off the strip follows the host
		held     = (decay_ms != '0) ? cur_rd : '0;
		lvl_new  = (q8_cap > {1'b0, held}) ? q8_cap[PEAK_W-1:0] : held;
	end

	// elapsed time times full scale, wrapped to 32 bits
	assign num = (now_q - stamp_q) * FULL_T;

	always_comb begin
		sat  = (|drop_q[TIME_W-1:PEAK_W]) || (drop_q[PEAK_W-1:0] >= cur_rd);
		dec  = sat ? '0 : cur_rd - drop_q[PEAK_W-1:0];
		bits = bar_of(dec, ROWS_W'(ROWS));
		hit  = !sent_q[idx] || (bits != shown_q[idx]);
	end

	always_comb begin
		is_last = 1'b1;
		for (int j = 0; j < STRIPS; j++)
			if ((IW'(j) > idx) && emit_q[j])
				is_last = 1'b0;
	end

	mpdb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (num),
		.divisor  (decay_ms),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STRIPS; i++) begin
				peak_q[i]  <= '0;
				shown_q[i] <= '0;
			end
			sent_q        <= '0;
			emit_q        <= '0;
			stamp_q       <= '0;
			stamp_valid_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.level_wr && strip_ok)
				peak_q[pidx] <= lvl_new;
			if (cmd.walk) begin
				peak_q[pidx] <= dec;
				emit_q[idx]  <= hit;
				if (hit) begin
					shown_q[idx] <= bits;
					sent_q[idx]  <= 1'b1;
				end
			end
			if (cmd.stamp_upd) begin
				stamp_q       <= now_q;
				stamp_valid_q <= 1'b1;
			end
			if (cmd.emit_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			now_q <= now_ms;
		if (cmd.drop_clear)
			drop_q <= '0;
		else if (cmd.drop_load)
			drop_q <= quotient;
		if (cmd.emit_load) begin
			out_strip_q <= STRIP_W'(idx);
			bar_q       <= shown_q[idx];
			last_q      <= is_last;
		end
	end

	always_comb begin
		stat.use_div  = (decay_ms != '0) && stamp_valid_q;
		stat.div_done = div_done;
		stat.emit_hit = emit_q[idx];
		stat.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_strip = out_strip_q;
	assign bar_bits  = bar_q;
	assign last      = last_q;

endmodule
`default_nettype wire

FILE: hw/rtl/mpdb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module mpdb_ctrl import mpdb_pkg::*; #(
	parameter int STRIPS = STRIPS_DEF,
	localparam int IW    = (STRIPS > 1) ? $clog2(STRIPS) : 1
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       kind,
	output logic            in_ready,
	input  wire mpdb_stat_t stat,
	output mpdb_cmd_t       cmd,
	output logic [IW-1:0]   idx
);

	localparam logic [IW-1:0] IDX_LAST = IW'(STRIPS - 1);

	mpdb_state_t   state_q;
	mpdb_state_t   state_d;
	logic [IW-1:0] idx_q;
	logic          idx_last;
	logic          idx_inc;
	logic          idx_clr;
	logic          advance;

	assign idx_last = (idx_q == IDX_LAST);
	assign advance  = !stat.emit_hit || stat.out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && (kind == KIND_TICK))
					state_d = ST_PREP;
			end
			ST_PREP: begin
				state_d = stat.use_div ? ST_DIV : ST_WALK;
			end
			ST_DIV: begin
				if (stat.div_done)
					state_d = ST_WALK;
			end
			ST_WALK: begin
				if (idx_last)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (advance && idx_last)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		idx_inc  = 1'b0;
		idx_clr  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready     = 1'b1;
				idx_clr      = 1'b1;
				cmd.level_wr = in_valid && (kind == KIND_LEVEL);
				cmd.capture  = in_valid && (kind == KIND_TICK);
			end
			ST_PREP: begin
				cmd.div_start  = stat.use_div;
				cmd.drop_clear = !stat.use_div;
			end
			ST_DIV: begin
				cmd.drop_load = stat.div_done;
			end
			ST_WALK: begin
				cmd.walk      = 1'b1;
				cmd.stamp_upd = idx_last;
				idx_inc       = !idx_last;
				idx_clr       = idx_last;
			end
			ST_EMIT: begin
				// hold the strip until the output register frees up
				cmd.emit_load = stat.emit_hit && stat.out_free;
				idx_inc       = advance && !idx_last;
				idx_clr       = advance && idx_last;
			end
			default: begin
				idx_clr = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (idx_clr)
				idx_q <= '0;
			else if (idx_inc)
				idx_q <= idx_q + IW'(1);
		end
	end

	assign idx = idx_q;

	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) && idx_last |=> (state_q == ST_EMIT) && (idx_q == '0))
		else $error("walk did not hand over to emit");

	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_PREP))
		else $error("tick item not taken into prep");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) && stat.emit_hit && !stat.out_free
		|=> (state_q == ST_EMIT) && $stable(idx_q))
		else $error("pending strip skipped under stall");

endmodule
`default_nettype wire

FILE: hw/rtl/meter_peak_decay_ballistics_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Peak meter with linear decay for up to eight strips. A level item (kind 0)
// updates one strip's held peak in the cycle it is accepted and gives no
// result. A tick item (kind 1) decays every strip by elapsed time times full
// scale over decay_ms, then sends one item per strip whose LED bar changed
// or was never sent, with last set on the final one. One 32-step restoring
// divider computes the common drop (skipped on the first tick after reset or
// with decay off), then the strips are updated one by one in a walk pass and
// sent in an emit pass, which holds on a strip while the output is held off.
// decay_ms sits at byte address 0 of the APB port and resets to 1000.
module meter_peak_decay_ballistics_top import mpdb_pkg::*; #(
	parameter int STRIPS = STRIPS_DEF,
	parameter int ROWS   = ROWS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [APB_AW-1:0]  paddr,
	input  wire logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]       prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               kind,
	input  wire logic [STRIP_W-1:0] strip,
	input  wire logic [LEVEL_W-1:0] level,
	input  wire logic [TIME_W-1:0]  now_ms,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [STRIP_W-1:0]      out_strip,
	output logic [BAR_W-1:0]        bar_bits,
	output logic                    last
);

	localparam int IW = (STRIPS > 1) ? $clog2(STRIPS) : 1;

	logic [DECAY_W-1:0] decay_q;
	mpdb_cmd_t          cmd;
	mpdb_stat_t         stat;
	logic [IW-1:0]      idx;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= DECAY_RST;
		end else if (psel && penable && pwrite && (paddr[2] == REG_DECAY)) begin
			decay_q <= pwdata[DECAY_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_DECAY)
			prdata = APB_DW'(decay_q);
	end

	mpdb_ctrl #(
		.STRIPS (STRIPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd),
		.idx      (idx)
	);

	mpdb_dp #(
		.STRIPS (STRIPS),
		.ROWS   (ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.idx       (idx),
		.stat      (stat),
		.strip     (strip),
		.level     (level),
		.now_ms    (now_ms),
		.decay_ms  (decay_q),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_strip (out_strip),
		.bar_bits  (bar_bits),
		.last      (last)
	);

endmodule
`default_nettype wire
